// ===== rtl/stl_pkg.sv =====
// ----------------------------------------------------------------------------
// stl_pkg: shared types and constants of the source text lexer
// Request and response payloads, scan modes, token kinds, character codes
// and the keyword patterns matched against the packed word prefix.
// ----------------------------------------------------------------------------
package stl_pkg;

   localparam int POSITION_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH           = 8;
   localparam int BURST_MAX             = 3;

   typedef struct packed {
      logic [7:0] source_byte;
      logic       end_of_source;
   } stl_req_type;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [15:0] token_start;
      logic [15:0] token_length;
      logic        run_end;
   } stl_rsp_type;

   // Tokens that one request produces, in emission order.
   typedef struct packed {
      logic [BURST_MAX-1:0]           valid;
      stl_rsp_type [BURST_MAX-1:0]    tok;
   } stl_burst_type;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'd0,
      MODE_WORD   = 3'd1,
      MODE_NUMBER = 3'd2,
      MODE_LINE   = 3'd3,
      MODE_SLASH  = 3'd4,
      MODE_BLOCK  = 3'd5,
      MODE_STAR   = 3'd6,
      MODE_QUOTE  = 3'd7
   } stl_mode_type;

   localparam logic [4:0] KIND_PRINT   = 5'd0;
   localparam logic [4:0] KIND_LET     = 5'd1;
   localparam logic [4:0] KIND_LPAREN  = 5'd2;
   localparam logic [4:0] KIND_RPAREN  = 5'd3;
   localparam logic [4:0] KIND_LBRACK  = 5'd4;
   localparam logic [4:0] KIND_RBRACK  = 5'd5;
   localparam logic [4:0] KIND_LBRACE  = 5'd6;
   localparam logic [4:0] KIND_RBRACE  = 5'd7;
   localparam logic [4:0] KIND_CHAR    = 5'd8;
   localparam logic [4:0] KIND_STRING  = 5'd9;
   localparam logic [4:0] KIND_OP      = 5'd10;
   localparam logic [4:0] KIND_NUMBER  = 5'd11;
   localparam logic [4:0] KIND_SEMI    = 5'd12;
   localparam logic [4:0] KIND_BOOL    = 5'd13;
   localparam logic [4:0] KIND_IDENT   = 5'd14;
   localparam logic [4:0] KIND_EOF     = 5'd15;
   localparam logic [4:0] KIND_ERROR   = 5'd16;

   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_SQUOTE  = 8'h27;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_RBRACK  = 8'h5D;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;

   localparam logic [39:0] PACK_PRINT = 40'h7072696E74;
   localparam logic [39:0] PACK_FALSE = 40'h66616C7365;
   localparam logic [39:0] PACK_LET   = 40'h00006C6574;
   localparam logic [39:0] PACK_TRUE  = 40'h0074727565;

   localparam logic [15:0] LEN_MAX = 16'hFFFF;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c inside {[8'h30:8'h39]});
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c inside {8'h20, [8'h09:8'h0D]});
   endfunction

   // Keywords only match at their exact length, so a saturated word stays an identifier.
   function automatic logic [4:0] word_kind(input logic [15:0] len, input logic [39:0] prefix);
      logic [4:0] kind;
      kind = KIND_IDENT;
      if (len == 16'd5 && prefix == PACK_PRINT) begin
         kind = KIND_PRINT;
      end else if (len == 16'd3 && prefix == PACK_LET) begin
         kind = KIND_LET;
      end else if (len == 16'd4 && prefix == PACK_TRUE) begin
         kind = KIND_BOOL;
      end else if (len == 16'd5 && prefix == PACK_FALSE) begin
         kind = KIND_BOOL;
      end
      return kind;
   endfunction

   function automatic stl_rsp_type make_tok(input logic [4:0] kind, input logic [15:0] start,
                                            input logic [15:0] len);
      stl_rsp_type t;
      t.token_kind   = kind;
      t.token_start  = start;
      t.token_length = len;
      t.run_end      = 1'b0;
      return t;
   endfunction

endpackage

// ===== rtl/stl_scanner.sv =====
// ----------------------------------------------------------------------------
// stl_scanner: scan state machine of the source text lexer
// Takes one byte per accepted request and produces the up to three tokens
// that byte completes, together with the next scan state.
// ----------------------------------------------------------------------------
module stl_scanner #(
   parameter int POSITION_BITS = stl_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  stl_pkg::stl_req_type   req_data,
   output stl_pkg::stl_burst_type burst
);
   import stl_pkg::*;

   localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

   stl_mode_type             mode_ff, mode_in;
   logic                     dq_ff, dq_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;
   logic [15:0]              len_ff, len_in;
   logic [39:0]              prefix_ff, prefix_in;

   logic [7:0]               c;
   logic                     last;
   logic                     run_idle;
   logic [15:0]              len_grown;
   logic [POSITION_BITS-1:0] pos_next;
   logic [7:0]               close_char;
   logic [BURST_MAX-1:0]     tok_valid;
   stl_rsp_type [BURST_MAX-1:0] tok;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         dq_ff     <= 1'b0;
         pos_ff    <= '0;
         start_ff  <= '0;
         len_ff    <= '0;
         prefix_ff <= '0;
      end else if (step_en) begin
         mode_ff   <= mode_in;
         dq_ff     <= dq_in;
         pos_ff    <= pos_in;
         start_ff  <= start_in;
         len_ff    <= len_in;
         prefix_ff <= prefix_in;
      end
   end

   always_comb begin
      c          = req_data.source_byte;
      last       = req_data.end_of_source;
      mode_in    = mode_ff;
      dq_in      = dq_ff;
      pos_in     = pos_ff;
      start_in   = start_ff;
      len_in     = len_ff;
      prefix_in  = prefix_ff;
      run_idle   = 1'b0;
      tok_valid  = '0;
      tok        = '0;
      len_grown  = (len_ff == LEN_MAX) ? len_ff : len_ff + 16'd1;
      pos_next   = pos_ff + POS_ONE;
      close_char = dq_ff ? CH_DQUOTE : CH_SQUOTE;

      // Slot 0: the run that this byte closes.
      case (mode_ff)
         MODE_WORD: begin
            if (is_alpha(c)) begin
               if (len_ff < 16'd5) begin
                  prefix_in = {prefix_ff[31:0], c};
               end
               len_in = len_grown;
            end else begin
               tok_valid[0] = 1'b1;
               tok[0]       = make_tok(word_kind(len_ff, prefix_ff), 16'(start_ff), len_ff);
               run_idle     = 1'b1;
            end
         end
         MODE_NUMBER: begin
            if (is_digit(c)) begin
               len_in = len_grown;
            end else begin
               tok_valid[0] = 1'b1;
               tok[0]       = make_tok(KIND_NUMBER, 16'(start_ff), len_ff);
               run_idle     = 1'b1;
            end
         end
         MODE_LINE: begin
            if (c == CH_NEWLINE) begin
               mode_in = MODE_IDLE;
            end
         end
         MODE_SLASH: begin
            if (c == CH_STAR) begin
               mode_in = MODE_BLOCK;
            end else begin
               tok_valid[0] = 1'b1;
               tok[0]       = make_tok(KIND_OP, 16'(start_ff), 16'd1);
               run_idle     = 1'b1;
            end
         end
         MODE_BLOCK: begin
            if (c == CH_STAR) begin
               mode_in = MODE_STAR;
            end
         end
         MODE_STAR: begin
            if (c == CH_SLASH) begin
               mode_in = MODE_IDLE;
            end else if (c != CH_STAR) begin
               mode_in = MODE_BLOCK;
            end
         end
         MODE_QUOTE: begin
            len_in = len_grown;
            if (c == close_char) begin
               tok_valid[0] = 1'b1;
               tok[0]       = make_tok(dq_ff ? KIND_STRING : KIND_CHAR, 16'(start_ff),
                                       len_grown);
               mode_in      = MODE_IDLE;
            end
         end
         default: begin
            run_idle = 1'b1;
         end
      endcase

      // Slot 1: a one-byte token, or a run that starts here.
      if (run_idle) begin
         mode_in = MODE_IDLE;
         if (is_alpha(c)) begin
            mode_in   = MODE_WORD;
            start_in  = pos_ff;
            len_in    = 16'd1;
            prefix_in = {32'd0, c};
         end else if (is_digit(c)) begin
            mode_in  = MODE_NUMBER;
            start_in = pos_ff;
            len_in   = 16'd1;
         end else if (!is_space(c)) begin
            case (c)
               CH_HASH: mode_in = MODE_LINE;
               CH_SLASH: begin
                  mode_in  = MODE_SLASH;
                  start_in = pos_ff;
                  len_in   = 16'd1;
               end
               CH_SQUOTE, CH_DQUOTE: begin
                  mode_in  = MODE_QUOTE;
                  start_in = pos_ff;
                  len_in   = 16'd1;
                  dq_in    = (c == CH_DQUOTE);
               end
               CH_LPAREN: begin
                  tok_valid[1] = 1'b1;
                  tok[1]       = make_tok(KIND_LPAREN, 16'(pos_ff), 16'd1);
               end
               CH_RPAREN: begin
                  tok_valid[1] = 1'b1;
                  tok[1]       = make_tok(KIND_RPAREN, 16'(pos_ff), 16'd1);
               end
               CH_LBRACK: begin
                  tok_valid[1] = 1'b1;
                  tok[1]       = make_tok(KIND_LBRACK, 16'(pos_ff), 16'd1);
               end
               CH_RBRACK: begin
                  tok_valid[1] = 1'b1;
                  tok[1]       = make_tok(KIND_RBRACK, 16'(pos_ff), 16'd1);
               end
               CH_LBRACE: begin
                  tok_valid[1] = 1'b1;
                  tok[1]       = make_tok(KIND_LBRACE, 16'(pos_ff), 16'd1);
               end
               CH_RBRACE: begin
                  tok_valid[1] = 1'b1;
                  tok[1]       = make_tok(KIND_RBRACE, 16'(pos_ff), 16'd1);
               end
               CH_PLUS, CH_MINUS, CH_STAR, CH_EQUAL: begin
                  tok_valid[1] = 1'b1;
                  tok[1]       = make_tok(KIND_OP, 16'(pos_ff), 16'd1);
               end
               CH_SEMI: begin
                  tok_valid[1] = 1'b1;
                  tok[1]       = make_tok(KIND_SEMI, 16'(pos_ff), 16'd1);
               end
               default: begin
               end
            endcase
         end
      end

      if (last) begin
         // A one-byte token always leaves the mode idle, so slot 1 is free here.
         case (mode_in)
            MODE_WORD: begin
               tok_valid[1] = 1'b1;
               tok[1]       = make_tok(word_kind(len_in, prefix_in), 16'(start_in), len_in);
            end
            MODE_NUMBER: begin
               tok_valid[1] = 1'b1;
               tok[1]       = make_tok(KIND_NUMBER, 16'(start_in), len_in);
            end
            MODE_SLASH: begin
               tok_valid[1] = 1'b1;
               tok[1]       = make_tok(KIND_OP, 16'(start_in), 16'd1);
            end
            MODE_QUOTE: begin
               tok_valid[1] = 1'b1;
               tok[1]       = make_tok(KIND_ERROR, 16'(start_in), len_in);
            end
            default: begin
            end
         endcase
         tok_valid[2] = 1'b1;
         tok[2]       = make_tok(KIND_EOF, 16'(pos_next), 16'd0);
         mode_in      = MODE_IDLE;
         dq_in        = 1'b0;
         pos_in       = '0;
         start_in     = '0;
         len_in       = '0;
         prefix_in    = '0;
      end else begin
         pos_in = pos_next;
      end

      tok[0].run_end = tok_valid[0] & ~tok_valid[1] & ~tok_valid[2];
      tok[1].run_end = tok_valid[1] & ~tok_valid[2];
      tok[2].run_end = tok_valid[2];

      burst.valid = tok_valid & {BURST_MAX{step_en}};
      burst.tok   = tok;
   end

endmodule

// ===== rtl/stl_rsp_queue.sv =====
// ----------------------------------------------------------------------------
// stl_rsp_queue: token queue of the source text lexer
// Stores up to three tokens per cycle in order and hands them out one per
// cycle on the response channel while the receiver takes them.
// ----------------------------------------------------------------------------
module stl_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  stl_pkg::stl_burst_type burst,
   output logic                   has_room,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output stl_pkg::stl_rsp_type   rsp_data
);
   import stl_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   stl_rsp_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] head_ff, head_in;
   logic [PTR_BITS-1:0] tail_ff, tail_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   logic [PTR_BITS-1:0] wr_addr [BURST_MAX];
   logic [1:0]          push_cnt;
   logic                pop;

   always_comb begin
      wr_addr[0] = tail_ff;
      wr_addr[1] = tail_ff + PTR_BITS'(burst.valid[0]);
      wr_addr[2] = tail_ff + PTR_BITS'(burst.valid[0]) + PTR_BITS'(burst.valid[1]);
      push_cnt   = 2'(burst.valid[0]) + 2'(burst.valid[1]) + 2'(burst.valid[2]);
      pop        = rsp_valid & rsp_ready;
      tail_in    = tail_ff + PTR_BITS'(push_cnt);
      head_in    = head_ff + PTR_BITS'(pop);
      count_in   = count_ff + CNT_BITS'(push_cnt) - CNT_BITS'(pop);
   end

   // Room for a full burst is judged without counting this cycle's pop.
   assign has_room  = (count_ff <= CNT_BITS'(QUEUE_DEPTH - BURST_MAX));
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entry_ff[head_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < BURST_MAX; i++) begin
         if (burst.valid[i]) begin
            entry_ff[wr_addr[i]] <= burst.tok[i];
         end
      end
   end

endmodule

// ===== rtl/source_text_lexer_core.sv =====
// ----------------------------------------------------------------------------
// source_text_lexer_core: streaming source text lexer
// Turns a byte stream into token descriptors (kind, start offset, length).
//
// The request channel (req_valid, req_ready, req_data) carries one source
// byte per request, with end_of_source set on the final byte of a text. The
// response channel (rsp_valid, rsp_ready, rsp_data) carries tokens in order;
// run_end marks the last token caused by a byte. A byte causes zero to three
// tokens; the final byte always adds an end-of-file token.
// A request is taken in every cycle while the eight-entry token queue has
// room for three more tokens, so the sustained rate is one byte per cycle as
// long as the receiver takes at least one token per byte. A byte's tokens
// are registered in the queue when the byte is accepted and leave one per
// cycle while the receiver takes them; when it stalls, tokens gather in
// the queue and req_ready drops once fewer than three entries are free.
// Reset empties the queue and returns the scanner to idle at offset zero;
// after the final byte of a text the scanner likewise starts over at zero.
// ----------------------------------------------------------------------------
module source_text_lexer_core #(
   parameter int POSITION_BITS = stl_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  stl_pkg::stl_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output stl_pkg::stl_rsp_type rsp_data
);
   import stl_pkg::*;

   logic          step_en;
   logic          has_room;
   stl_burst_type burst;

   assign req_ready = has_room;
   assign step_en   = req_valid & has_room;

   stl_scanner #(
      .POSITION_BITS(POSITION_BITS)
   ) u_scanner (
      .clock    (clock),
      .reset    (reset),
      .step_en  (step_en),
      .req_data (req_data),
      .burst    (burst)
   );

   stl_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .burst     (burst),
      .has_room  (has_room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the source text lexer core
// Streams short directed texts and randomly composed texts through the
// request channel, predicts every token from its own copy of the scanner
// state and compares each response with the oldest prediction, under three
// patterns of sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_top;
   import stl_pkg::*;

   localparam int QUIET_LIMIT = 1000;
   localparam int REPORT_LIMIT = 10;

   // Tracks the scanner of the lexer and the tokens it still owes.
   class token_tracker;
      stl_rsp_type  due_tokens[$];
      stl_rsp_type  burst[$];
      int unsigned  mismatch_count;
      stl_mode_type mode;
      bit           dq_close;
      logic [15:0]  offset;
      logic [15:0]  run_start;
      logic [15:0]  run_len;
      logic [39:0]  word_head;

      function new();
         restart();
         mismatch_count = 0;
      endfunction

      function void restart();
         mode      = MODE_IDLE;
         dq_close  = 1'b0;
         offset    = '0;
         run_start = '0;
         run_len   = '0;
         word_head = '0;
      endfunction

      function bit letter(logic [7:0] c);
         return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
      endfunction

      function bit digit(logic [7:0] c);
         return c >= 8'h30 && c <= 8'h39;
      endfunction

      function bit blank(logic [7:0] c);
         return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
      endfunction

      function void add(logic [4:0] kind, logic [15:0] start, logic [15:0] len);
         stl_rsp_type t;
         t.token_kind   = kind;
         t.token_start  = start;
         t.token_length = len;
         t.run_end      = 1'b0;
         burst.insert(burst.size(), t);
      endfunction

      function void begin_run(stl_mode_type m, logic [15:0] at);
         mode      = m;
         run_start = at;
         run_len   = 16'd1;
      endfunction

      function void lengthen();
         if (run_len != LEN_MAX) begin
            run_len = run_len + 16'd1;
         end
      endfunction

      // Keywords count only at their exact length; the head freezes after five letters.
      function logic [4:0] word_token();
         logic [4:0] kind;
         kind = KIND_IDENT;
         case (word_head)
            PACK_PRINT: if (run_len == 16'd5) kind = KIND_PRINT;
            PACK_FALSE: if (run_len == 16'd5) kind = KIND_BOOL;
            PACK_TRUE:  if (run_len == 16'd4) kind = KIND_BOOL;
            PACK_LET:   if (run_len == 16'd3) kind = KIND_LET;
            default: ;
         endcase
         return kind;
      endfunction

      function void from_idle(logic [7:0] c, logic [15:0] at);
         mode = MODE_IDLE;
         if (blank(c)) begin
            return;
         end
         if (letter(c)) begin
            begin_run(MODE_WORD, at);
            word_head = {32'd0, c};
         end else if (digit(c)) begin
            begin_run(MODE_NUMBER, at);
         end else begin
            case (c)
               CH_HASH:   mode = MODE_LINE;
               CH_SLASH:  begin_run(MODE_SLASH, at);
               CH_SQUOTE, CH_DQUOTE: begin
                  begin_run(MODE_QUOTE, at);
                  dq_close = (c == CH_DQUOTE);
               end
               CH_LPAREN: add(KIND_LPAREN, at, 16'd1);
               CH_RPAREN: add(KIND_RPAREN, at, 16'd1);
               CH_LBRACK: add(KIND_LBRACK, at, 16'd1);
               CH_RBRACK: add(KIND_RBRACK, at, 16'd1);
               CH_LBRACE: add(KIND_LBRACE, at, 16'd1);
               CH_RBRACE: add(KIND_RBRACE, at, 16'd1);
               CH_PLUS, CH_MINUS, CH_STAR, CH_EQUAL: add(KIND_OP, at, 16'd1);
               CH_SEMI:   add(KIND_SEMI, at, 16'd1);
               default: ;
            endcase
         end
      endfunction

      // Works out the tokens that one accepted request causes.
      function void lex_byte(stl_req_type req);
         logic [7:0]  c;
         logic [15:0] at;
         stl_rsp_type t;
         c  = req.source_byte;
         at = offset;
         burst.delete();
         case (mode)
            MODE_WORD: begin
               if (letter(c)) begin
                  if (run_len < 16'd5) word_head = {word_head[31:0], c};
                  lengthen();
               end else begin
                  add(word_token(), run_start, run_len);
                  from_idle(c, at);
               end
            end
            MODE_NUMBER: begin
               if (digit(c)) begin
                  lengthen();
               end else begin
                  add(KIND_NUMBER, run_start, run_len);
                  from_idle(c, at);
               end
            end
            MODE_LINE: if (c == CH_NEWLINE) mode = MODE_IDLE;
            MODE_SLASH: begin
               if (c == CH_STAR) begin
                  mode = MODE_BLOCK;
               end else begin
                  add(KIND_OP, run_start, 16'd1);
                  from_idle(c, at);
               end
            end
            MODE_BLOCK: if (c == CH_STAR) mode = MODE_STAR;
            MODE_STAR: begin
               if (c == CH_SLASH) begin
                  mode = MODE_IDLE;
               end else if (c != CH_STAR) begin
                  mode = MODE_BLOCK;
               end
            end
            MODE_QUOTE: begin
               lengthen();
               if (c == (dq_close ? CH_DQUOTE : CH_SQUOTE)) begin
                  add(dq_close ? KIND_STRING : KIND_CHAR, run_start, run_len);
                  mode = MODE_IDLE;
               end
            end
            default: from_idle(c, at);
         endcase

         if (req.end_of_source) begin
            case (mode)
               MODE_WORD:   add(word_token(), run_start, run_len);
               MODE_NUMBER: add(KIND_NUMBER, run_start, run_len);
               MODE_SLASH:  add(KIND_OP, run_start, 16'd1);
               MODE_QUOTE:  add(KIND_ERROR, run_start, run_len);
               default: ;
            endcase
            add(KIND_EOF, at + 16'd1, 16'd0);
            restart();
         end else begin
            offset = at + 16'd1;
         end

         foreach (burst[i]) begin
            t = burst[i];
            t.run_end = (i == burst.size() - 1);
            due_tokens.insert(due_tokens.size(), t);
         end
      endfunction

      function void check_token(stl_rsp_type got);
         stl_rsp_type want;
         if (due_tokens.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("unexpected token: kind %0d start %0d length %0d end %0b",
                        got.token_kind, got.token_start, got.token_length, got.run_end);
            end
            return;
         end
         want = due_tokens.pop_front();
         if (got.token_kind !== want.token_kind || got.token_start !== want.token_start ||
             got.token_length !== want.token_length || got.run_end !== want.run_end) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("token mismatch: expected kind %0d start %0d length %0d end %0b",
                        want.token_kind, want.token_start, want.token_length, want.run_end);
               $display("                got      kind %0d start %0d length %0d end %0b",
                        got.token_kind, got.token_start, got.token_length, got.run_end);
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   stl_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   stl_rsp_type rsp_data;

   token_tracker tokens = new();
   logic [7:0]   src_text[$];
   int           token_bytes = 0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   int           quiet_cycles = 0;

   source_text_lexer_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Both handshakes are observed here, so a request is always predicted
   // before any token of the same edge is checked.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (req_valid && req_ready) tokens.lex_byte(req_data);
         if (rsp_valid && rsp_ready) tokens.check_token(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   function automatic void put_byte(logic [7:0] b);
      src_text.insert(src_text.size(), b);
   endfunction

   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) begin
         put_byte(s[i]);
      end
   endfunction

   function automatic logic [7:0] any_letter();
      logic [7:0] base;
      base = $urandom_range(1) ? 8'h61 : 8'h41;
      return base + 8'($urandom_range(25));
   endfunction

   function automatic logic [7:0] quoted_char(logic [7:0] close);
      logic [7:0] c;
      c = 8'h20 + 8'($urandom_range(94));
      return (c == close) ? 8'h71 : c;
   endfunction

   function automatic void add_lexeme();
      int         first;
      int         pick;
      string      punct;
      logic [7:0] close;
      first = src_text.size();
      punct = "()[]{};+-*/=";
      pick  = $urandom_range(15);
      case (pick)
         0, 1: begin
            case ($urandom_range(5))
               0: put_text("print");
               1: put_text("let");
               2: put_text("true");
               3: put_text("false");
               4: put_text("Let");
               default: put_text("prin");
            endcase
         end
         2, 3: repeat ($urandom_range(1, 7)) put_byte(any_letter());
         4: repeat ($urandom_range(1, 5)) put_byte(8'h30 + 8'($urandom_range(9)));
         5, 6: begin
            close = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
            put_byte(close);
            repeat ($urandom_range(0, 4)) put_byte(quoted_char(close));
            put_byte(close);
         end
         7, 8, 9: put_byte(punct[$urandom_range(11)]);
         10, 11: begin
            case ($urandom_range(3))
               0: put_byte(8'h20);
               1: put_byte(8'h09);
               2: put_byte(CH_NEWLINE);
               default: put_byte(8'h0B);
            endcase
         end
         12: begin
            put_byte(CH_HASH);
            repeat ($urandom_range(0, 4)) put_byte(8'($urandom_range(255)));
            put_byte(CH_NEWLINE);
         end
         13: begin
            put_text("/*");
            repeat ($urandom_range(0, 5)) begin
               put_byte(($urandom_range(2) == 0) ? CH_STAR : 8'($urandom_range(255)));
            end
            put_text("*/");
         end
         default: put_byte(8'($urandom_range(255)));
      endcase
      if (pick <= 9) token_bytes += src_text.size() - first;
   endfunction

   // Mostly well-formed texts; now and then one is cut short.
   function automatic void compose_text();
      int keep;
      src_text.delete();
      repeat ($urandom_range(2, 7)) add_lexeme();
      if ($urandom_range(7) == 0) begin
         keep = $urandom_range(1, src_text.size());
         while (src_text.size() > keep) void'(src_text.pop_back());
      end
   endfunction

   task automatic send_byte(input stl_req_type item);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_text();
      stl_req_type item;
      foreach (src_text[i]) begin
         item.source_byte   = src_text[i];
         item.end_of_source = (i == src_text.size() - 1);
         send_byte(item);
      end
      src_text.delete();
   endtask

   task automatic run_random(input int target);
      int first;
      first = token_bytes;
      while (token_bytes - first < target) begin
         compose_text();
         send_text();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 21;
      recv_idle_pct = 59;
      // A keyword, brackets, a number and a char literal closing on the final byte.
      put_text("[let{7]'a'");
      send_text();
      // A slash right after the opener, the byte after the closer, ignored
      // bytes at both extremes, a line comment and an unterminated quote.
      put_text("/*/*/;");
      put_byte(8'hFF);
      put_byte(8'h00);
      put_text("=#\n'z");
      send_text();
      // Bool, identifier, string, operators and a lone slash as the final byte.
      put_text("true(x)\"s\"+*-/");
      send_text();
      // Block comment left open at the end of the text.
      put_text("/*");
      send_text();
      run_random(10);

      send_idle_pct = 59;
      recv_idle_pct = 21;
      run_random(10);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(10);

      req_valid <= 1'b0;
      while (tokens.due_tokens.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (tokens.mismatch_count == 0 && tokens.due_tokens.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
